### rtl/rc4_pkg.sv
package rc4_pkg;

   localparam int RC4_KEY_DEPTH = 256;
   localparam int KEY_LEN_W     = 9;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd4;

   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_MIX_RD,
      ST_MIX_J,
      ST_MIX_WK,
      ST_MIX_WJ,
      ST_DATA_RD,
      ST_DATA_J,
      ST_DATA_SW,
      ST_DATA_KS
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_MIX_RD,
      OP_MIX_J,
      OP_MIX_WK,
      OP_MIX_WJ,
      OP_DATA_RD,
      OP_DATA_J,
      OP_DATA_SW,
      OP_DATA_KS
   } op_type;

   typedef struct packed {
      op_type op;
      logic   key_wr;   // store req key byte this cycle
      logic   capture;  // latch data word and message flag
   } cmd_type;

   typedef struct packed {
      logic cnt_last;   // round counter at 255
      logic out_free;   // output register can take a word
   } sts_type;

endpackage

### rtl/rc4_ctrl.sv
module rc4_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic             req_last_of_message,
   input  rc4_pkg::sts_type sts,
   output rc4_pkg::cmd_type cmd
);
   import rc4_pkg::*;

   state_type state_ff, state_in;
   logic      needs_ff, needs_in;
   logic      take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         needs_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         needs_ff <= needs_in;
      end
   end

   assign take = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      needs_in    = needs_ff;
      req_ready   = 1'b0;
      cmd.op      = OP_NONE;
      cmd.key_wr  = 1'b0;
      cmd.capture = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (take && req_func == FUNC_KEY) begin
               cmd.key_wr = 1'b1;
            end else if (take) begin
               // first read of S[i+1] goes out with the accept
               cmd.op      = OP_DATA_RD;
               cmd.capture = 1'b1;
               needs_in    = req_last_of_message;
               state_in    = needs_ff ? ST_INIT : ST_DATA_J;
            end
         end
         ST_INIT: begin
            cmd.op = OP_INIT;
            if (sts.cnt_last) state_in = ST_MIX_RD;
         end
         ST_MIX_RD: begin
            cmd.op   = OP_MIX_RD;
            state_in = ST_MIX_J;
         end
         ST_MIX_J: begin
            cmd.op   = OP_MIX_J;
            state_in = ST_MIX_WK;
         end
         ST_MIX_WK: begin
            cmd.op   = OP_MIX_WK;
            state_in = ST_MIX_WJ;
         end
         ST_MIX_WJ: begin
            cmd.op   = OP_MIX_WJ;
            state_in = sts.cnt_last ? ST_DATA_RD : ST_MIX_RD;
         end
         ST_DATA_RD: begin
            cmd.op   = OP_DATA_RD;
            state_in = ST_DATA_J;
         end
         ST_DATA_J: begin
            cmd.op   = OP_DATA_J;
            state_in = ST_DATA_SW;
         end
         ST_DATA_SW: begin
            cmd.op   = OP_DATA_SW;
            state_in = ST_DATA_KS;
         end
         ST_DATA_KS: begin
            cmd.op = OP_DATA_KS;
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_sched_on_rekey: assert property (@(posedge clock) disable iff (reset)
      take && req_func == FUNC_DATA && needs_ff |=> state_ff == ST_INIT)
      else $error("re-key not started");

   a_mix_to_data: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MIX_WJ && sts.cnt_last |=> state_ff == ST_DATA_RD)
      else $error("schedule end missed");

   a_mix_clears_needs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MIX_RD |-> !needs_ff || $past(needs_ff) == needs_ff)
      else $error("schedule flag changed mid schedule");

endmodule

### rtl/rc4_dpath.sv
module rc4_dpath #(
   parameter int KEY_DEPTH = rc4_pkg::RC4_KEY_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rc4_pkg::cmd_type              cmd,
   output rc4_pkg::sts_type              sts,
   input  logic [7:0]                    req_key_index,
   input  logic [7:0]                    req_value,
   input  logic                          req_last_of_message,
   input  logic                          csr_wr_en,
   input  logic [rc4_pkg::KEY_LEN_W-1:0] csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_cipher_byte,
   output logic                          rsp_message_end
);
   import rc4_pkg::*;

   localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam logic [KEY_LEN_W-1:0] KEY_DEPTH_LEN = KEY_LEN_W'(KEY_DEPTH);

   logic [7:0] sbox_mem [256];
   logic [7:0] key_mem  [KEY_DEPTH];

   logic [KEY_LEN_W-1:0] key_len_ff;
   logic [KEY_LEN_W-1:0] len_eff;

   logic [7:0] cnt_ff,   cnt_in;
   logic [7:0] kpos_ff,  kpos_in;
   logic [7:0] mix_j_ff, mix_j_in;
   logic [7:0] idx_i_ff, idx_i_in;
   logic [7:0] idx_j_ff, idx_j_in;
   logic [7:0] sa_ff,    sa_in;
   logic [7:0] sb_ff,    sb_in;
   logic [7:0] t_ff,     t_in;
   logic [7:0] val_ff;
   logic       last_ff;
   logic [7:0] rdata_ff;
   logic [7:0] kdata_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] cipher_ff;
   logic       end_ff;

   logic       sb_wr_en, sb_rd_en;
   logic [7:0] sb_wr_addr, sb_wr_data, sb_rd_addr;
   logic       key_wr_ok;
   logic [7:0] j_sum, ks, i_next;
   logic       load_out;

   assign len_eff = (key_len_ff == '0 || key_len_ff > KEY_DEPTH_LEN) ?
                    KEY_DEPTH_LEN : key_len_ff;
   assign i_next  = idx_i_ff + 8'd1;
   assign key_wr_ok = cmd.key_wr && ({1'b0, req_key_index} < KEY_DEPTH_LEN);

   // post-swap forwarding: S[i] now holds sb, S[j] holds sa
   assign ks = (t_ff == idx_i_ff) ? sb_ff :
               (t_ff == idx_j_ff) ? sa_ff : rdata_ff;

   assign sts.cnt_last = (cnt_ff == 8'hFF);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign load_out     = (cmd.op == OP_DATA_KS) && sts.out_free;

   always_comb begin
      cnt_in     = cnt_ff;
      kpos_in    = kpos_ff;
      mix_j_in   = mix_j_ff;
      idx_i_in   = idx_i_ff;
      idx_j_in   = idx_j_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      t_in       = t_ff;
      j_sum      = 8'd0;
      sb_wr_en   = 1'b0;
      sb_wr_addr = 8'd0;
      sb_wr_data = 8'd0;
      sb_rd_en   = 1'b0;
      sb_rd_addr = 8'd0;
      case (cmd.op)
         OP_INIT: begin
            sb_wr_en   = 1'b1;
            sb_wr_addr = cnt_ff;
            sb_wr_data = cnt_ff;
            cnt_in     = cnt_ff + 8'd1;
            kpos_in    = 8'd0;
            mix_j_in   = 8'd0;
         end
         OP_MIX_RD: begin
            sb_rd_en   = 1'b1;
            sb_rd_addr = cnt_ff;
         end
         OP_MIX_J: begin
            j_sum      = mix_j_ff + rdata_ff + kdata_ff;
            mix_j_in   = j_sum;
            sa_in      = rdata_ff;
            sb_rd_en   = 1'b1;
            sb_rd_addr = j_sum;
         end
         OP_MIX_WK: begin
            sb_wr_en   = 1'b1;
            sb_wr_addr = cnt_ff;
            sb_wr_data = rdata_ff;
         end
         OP_MIX_WJ: begin
            sb_wr_en   = 1'b1;
            sb_wr_addr = mix_j_ff;
            sb_wr_data = sa_ff;
            cnt_in     = cnt_ff + 8'd1;
            kpos_in    = ((KEY_LEN_W'(kpos_ff) + 1'b1) == len_eff) ? 8'd0 :
                         kpos_ff + 8'd1;
            if (cnt_ff == 8'hFF) begin
               idx_i_in = 8'd0;
               idx_j_in = 8'd0;
            end
         end
         OP_DATA_RD: begin
            sb_rd_en   = 1'b1;
            sb_rd_addr = i_next;
         end
         OP_DATA_J: begin
            j_sum      = idx_j_ff + rdata_ff;
            idx_i_in   = i_next;
            idx_j_in   = j_sum;
            sa_in      = rdata_ff;
            sb_rd_en   = 1'b1;
            sb_rd_addr = j_sum;
         end
         OP_DATA_SW: begin
            sb_wr_en   = 1'b1;
            sb_wr_addr = idx_i_ff;
            sb_wr_data = rdata_ff;
            sb_in      = rdata_ff;
            t_in       = sa_ff + rdata_ff;
            sb_rd_en   = 1'b1;
            sb_rd_addr = sa_ff + rdata_ff;
         end
         OP_DATA_KS: begin
            // repeats harmlessly while the output stalls
            sb_wr_en   = 1'b1;
            sb_wr_addr = idx_j_ff;
            sb_wr_data = sa_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (sb_wr_en) sbox_mem[sb_wr_addr] <= sb_wr_data;
      if (sb_rd_en) rdata_ff <= sbox_mem[sb_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_wr_ok) key_mem[req_key_index[KEY_AW-1:0]] <= req_value;
      if (cmd.op == OP_MIX_RD) kdata_ff <= key_mem[kpos_ff[KEY_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff   <= KEY_LEN_RESET;
         cnt_ff       <= 8'd0;
         kpos_ff      <= 8'd0;
         mix_j_ff     <= 8'd0;
         idx_i_ff     <= 8'd0;
         idx_j_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) key_len_ff <= csr_wr_data;
         cnt_ff       <= cnt_in;
         kpos_ff      <= kpos_in;
         mix_j_ff     <= mix_j_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      t_ff  <= t_in;
      if (cmd.capture) begin
         val_ff  <= req_value;
         last_ff <= req_last_of_message;
      end
      if (load_out) begin
         cipher_ff <= val_ff ^ ks;
         end_ff    <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_byte = cipher_ff;
   assign rsp_message_end = end_ff;

   a_init_step: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_INIT |=> cnt_ff == $past(cnt_ff) + 8'd1)
      else $error("init counter did not advance");

   a_idx_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_MIX_WJ && cnt_ff == 8'hFF |=> idx_i_ff == 8'd0 && idx_j_ff == 8'd0)
      else $error("indices not cleared after schedule");

   a_ks_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DATA_KS && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("keystream word not loaded");

endmodule

### rtl/rc4_stream_cipher.sv
// RC4 cipher, one data word in, one word out; key words give no output.
// Data word: read i on accept, then read j, write i with keystream read, write j;
// the output register loads in the write-j step, which holds while the output stalls.
// No new word is taken before that. The first data word of a message adds the key
// schedule: S-box fill, then 256 rounds of read i, read j, write i, write j.
// Reset (synchronous, active high): indices zero, re-key pending, key_length 4.
module rc4_stream_cipher #(
   parameter int KEY_DEPTH = rc4_pkg::RC4_KEY_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [7:0]                    req_key_index,
   input  logic [7:0]                    req_value,
   input  logic                          req_last_of_message,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_cipher_byte,
   output logic                          rsp_message_end,
   // key length register
   input  logic                          csr_wr_en,
   input  logic [rc4_pkg::KEY_LEN_W-1:0] csr_wr_data
);
   import rc4_pkg::*;

   // controller sequences fill, mix and per-word steps
   cmd_type cmd;
   sts_type sts;

   rc4_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_last_of_message (req_last_of_message),
      .sts                 (sts),
      .cmd                 (cmd)
   );

   // datapath: S-box and key memories, indices, output register
   rc4_dpath #(
      .KEY_DEPTH (KEY_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_key_index       (req_key_index),
      .req_value           (req_value),
      .req_last_of_message (req_last_of_message),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cipher_byte     (rsp_cipher_byte),
      .rsp_message_end     (rsp_message_end)
   );

endmodule
